// ----- sv/awbsf_pkg.sv -----
package awbsf_pkg;

    // ALU operation codes, instruction bits 24..21
    typedef enum logic [3:0] {
        OP_AND = 4'h0,
        OP_EOR = 4'h1,
        OP_SUB = 4'h2,
        OP_RSB = 4'h3,
        OP_ADD = 4'h4,
        OP_ADC = 4'h5,
        OP_SBC = 4'h6,
        OP_RSC = 4'h7,
        OP_TST = 4'h8,
        OP_TEQ = 4'h9,
        OP_CMP = 4'hA,
        OP_CMN = 4'hB,
        OP_ORR = 4'hC,
        OP_MOV = 4'hD,
        OP_BIC = 4'hE,
        OP_MVN = 4'hF
    } awbsf_op_t;

    // Barrel shifter types, instruction bits 6..5
    typedef enum logic [1:0] {
        SH_LSL = 2'd0,
        SH_LSR = 2'd1,
        SH_ASR = 2'd2,
        SH_ROR = 2'd3
    } awbsf_shtype_t;

    // Register number of the program counter
    localparam logic [3:0] PC_INDEX = 4'hF;

    // One input item
    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] first_operand;
        logic [31:0] shift_source;
        logic [31:0] shift_register_value;
        logic        c_flag_in;
        logic        overflow_in;
        logic        privileged;
    } awbsf_in_t;

    // One result item
    typedef struct packed {
        logic [31:0] result;
        logic        write_dest;
        logic [3:0]  dest_index;
        logic        flags_update;
        logic        flag_n;
        logic        flag_z;
        logic        flag_c;
        logic        flag_v;
        logic        restore_saved_status;
        logic        extra_cycle;
    } awbsf_out_t;

    // Second operand and shifter carry
    typedef struct packed {
        logic [31:0] operand;
        logic        carry;
    } awbsf_shift_t;

endpackage

// ----- sv/awbsf_shifter.sv -----
module awbsf_shifter (
    input  awbsf_pkg::awbsf_in_t    item,
    output awbsf_pkg::awbsf_shift_t shift
);
    import awbsf_pkg::*;

    logic [31:0]   ins;
    logic [31:0]   rm;
    logic          sign;
    logic          cin;
    awbsf_shtype_t shtype;
    logic [4:0]    amt;
    logic [7:0]    reg_amt;
    logic          reg_zero;
    logic          reg_big;
    logic          reg_eq32;
    logic [4:0]    imm_rot;
    logic [63:0]   imm_dbl;
    logic [31:0]   imm_val;
    logic [63:0]   lsl_w;
    logic [32:0]   lsr_w;
    logic [32:0]   asr_w;
    logic [63:0]   ror_dbl;
    logic [31:0]   ror_val;

    assign ins      = item.instruction;
    assign rm       = item.shift_source;
    assign sign     = rm[31];
    assign cin      = item.c_flag_in;
    assign shtype   = awbsf_shtype_t'(ins[6:5]);
    assign reg_amt  = item.shift_register_value[7:0];
    assign reg_zero = (reg_amt == 8'd0);
    assign reg_big  = |reg_amt[7:5];
    assign reg_eq32 = (reg_amt == 8'd32);

    // Pick the 5-bit amount from register or immediate field
    assign amt = ins[4] ? reg_amt[4:0] : ins[11:7];

    // Rotated 8-bit immediate
    assign imm_rot = {ins[11:8], 1'b0};
    assign imm_dbl = {24'd0, ins[7:0], 24'd0, ins[7:0]} >> imm_rot;
    assign imm_val = imm_dbl[31:0];

    // Shared shift units for amounts 0..31
    assign lsl_w   = {32'd0, rm} << amt;
    assign lsr_w   = {rm, 1'b0} >> amt;
    assign asr_w   = 33'($signed({rm, 1'b0}) >>> amt);
    assign ror_dbl = {rm, rm} >> amt;
    assign ror_val = ror_dbl[31:0];

    // Select operand and carry by encoding
    always_comb
    begin
        shift.operand = rm;
        shift.carry   = cin;
        if (ins[25])
        begin
            shift.operand = imm_val;
            shift.carry   = (imm_rot == 5'd0) ? cin : imm_val[31];
        end
        else if (ins[4])
        begin
            if (!reg_zero)
            begin
                case (shtype)
                    SH_LSL:
                    begin
                        if (reg_big || reg_eq32)
                        begin
                            shift.operand = 32'd0;
                            shift.carry   = reg_eq32 & rm[0];
                        end
                        else
                        begin
                            shift.operand = lsl_w[31:0];
                            shift.carry   = lsl_w[32];
                        end
                    end
                    SH_LSR:
                    begin
                        if (reg_big || reg_eq32)
                        begin
                            shift.operand = 32'd0;
                            shift.carry   = reg_eq32 & sign;
                        end
                        else
                        begin
                            shift.operand = lsr_w[32:1];
                            shift.carry   = lsr_w[0];
                        end
                    end
                    SH_ASR:
                    begin
                        if (reg_big || reg_eq32)
                        begin
                            shift.operand = {32{sign}};
                            shift.carry   = sign;
                        end
                        else
                        begin
                            shift.operand = asr_w[32:1];
                            shift.carry   = asr_w[0];
                        end
                    end
                    default:
                    begin
                        if (amt == 5'd0)
                        begin
                            shift.operand = rm;
                            shift.carry   = sign;
                        end
                        else
                        begin
                            shift.operand = ror_val;
                            shift.carry   = ror_val[31];
                        end
                    end
                endcase
            end
        end
        else
        begin
            case (shtype)
                SH_LSL:
                begin
                    if (amt != 5'd0)
                    begin
                        shift.operand = lsl_w[31:0];
                        shift.carry   = lsl_w[32];
                    end
                end
                SH_LSR:
                begin
                    if (amt == 5'd0)
                    begin
                        shift.operand = 32'd0;
                        shift.carry   = sign;
                    end
                    else
                    begin
                        shift.operand = lsr_w[32:1];
                        shift.carry   = lsr_w[0];
                    end
                end
                SH_ASR:
                begin
                    if (amt == 5'd0)
                    begin
                        shift.operand = {32{sign}};
                        shift.carry   = sign;
                    end
                    else
                    begin
                        shift.operand = asr_w[32:1];
                        shift.carry   = asr_w[0];
                    end
                end
                default:
                begin
                    // zero amount encodes rotate right extended
                    if (amt == 5'd0)
                    begin
                        shift.operand = {cin, rm[31:1]};
                        shift.carry   = rm[0];
                    end
                    else
                    begin
                        shift.operand = ror_val;
                        shift.carry   = ror_val[31];
                    end
                end
            endcase
        end
    end

endmodule

// ----- sv/awbsf_alu.sv -----
module awbsf_alu (
    input  awbsf_pkg::awbsf_in_t    item,
    input  awbsf_pkg::awbsf_shift_t shift,
    output awbsf_pkg::awbsf_out_t   res
);
    import awbsf_pkg::*;

    awbsf_op_t   op;
    logic        s_bit;
    logic [3:0]  rd;
    logic [31:0] op1;
    logic [31:0] op2;
    logic [31:0] add_a;
    logic [31:0] add_b;
    logic        add_c;
    logic        arith;
    logic [32:0] sum;
    logic        sum_v;
    logic [31:0] r;
    logic        restore;

    assign op    = awbsf_op_t'(item.instruction[24:21]);
    assign s_bit = item.instruction[20];
    assign rd    = item.instruction[15:12];
    assign op1   = item.first_operand;
    assign op2   = shift.operand;

    // Steer adder operands and carry for the arithmetic opcodes
    always_comb
    begin
        add_a = op1;
        add_b = op2;
        add_c = 1'b0;
        arith = 1'b1;
        case (op)
            OP_SUB, OP_CMP:
            begin
                add_b = ~op2;
                add_c = 1'b1;
            end
            OP_RSB:
            begin
                add_a = op2;
                add_b = ~op1;
                add_c = 1'b1;
            end
            OP_ADD, OP_CMN:
            begin
                add_c = 1'b0;
            end
            OP_ADC:
            begin
                add_c = item.c_flag_in;
            end
            OP_SBC:
            begin
                add_b = ~op2;
                add_c = item.c_flag_in;
            end
            OP_RSC:
            begin
                add_a = op2;
                add_b = ~op1;
                add_c = item.c_flag_in;
            end
            default:
            begin
                arith = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_c};
    assign sum_v = (add_a[31] ^ sum[31]) & (add_b[31] ^ sum[31]);

    // Logical result selection, adder sum for the arithmetic opcodes
    always_comb
    begin
        case (op)
            OP_AND, OP_TST: r = op1 & op2;
            OP_EOR, OP_TEQ: r = op1 ^ op2;
            OP_ORR:         r = op1 | op2;
            OP_MOV:         r = op2;
            OP_BIC:         r = op1 & ~op2;
            OP_MVN:         r = ~op2;
            default:        r = sum[31:0];
        endcase
    end

    assign restore = s_bit && (rd == PC_INDEX) && item.privileged;

    // Assemble the result item
    always_comb
    begin
        res.result               = r;
        res.write_dest           = !(op == OP_TST || op == OP_TEQ ||
                                     op == OP_CMP || op == OP_CMN);
        res.dest_index           = rd;
        res.flags_update         = s_bit && !restore;
        res.flag_n               = r[31];
        res.flag_z               = (r == 32'd0);
        res.flag_c               = arith ? sum[32] : shift.carry;
        res.flag_v               = arith ? sum_v : item.overflow_in;
        res.restore_saved_status = restore;
        res.extra_cycle          = !item.instruction[25] && item.instruction[4];
    end

endmodule

// ----- sv/alu_with_barrel_shifter_flags_core.sv -----
// Data-processing execute unit: barrel shifter plus ALU with N Z C V flags.
//
// Input channel instr (instr_valid / instr_ready) carries one instruction
// word with its operand values, carry, overflow and mode bit. Output
// channel res (res_valid / res_ready) carries the result, destination,
// new flags, restore request and extra-cycle flag.
//
// An accepted item is held in an input register; the shifter and ALU
// work on it combinationally and the answer lands in a result register.
// The input register hands its item to the result register, which sets
// res_valid, whenever the result register is free or draining.
// Throughput is one item per cycle while res_ready stays high; the
// shifter-plus-adder path between the two registers sets the clock.
//
// Reset clears both valid bits; payload registers are not reset.
// When res_ready is low the result register holds, the input register
// still takes one more item, and instr_ready then drops until the
// receiver takes the waiting result. instr_ready depends on res_ready
// combinationally.
module alu_with_barrel_shifter_flags_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  instr_valid,
    output logic                  instr_ready,
    input  awbsf_pkg::awbsf_in_t  instr,
    output logic                  res_valid,
    input  logic                  res_ready,
    output awbsf_pkg::awbsf_out_t res
);
    import awbsf_pkg::*;

    awbsf_in_t    s1_reg;
    logic         s1_valid_reg;
    logic         s1_valid_next;
    awbsf_out_t   res_reg;
    logic         res_valid_reg;
    logic         res_valid_next;
    logic         s1_fire;
    awbsf_shift_t shift;
    awbsf_out_t   alu_res;

    // Advance stage one when the result register is free or draining
    assign s1_fire     = !res_valid_reg || res_ready;
    assign instr_ready = !s1_valid_reg || s1_fire;

    assign s1_valid_next  = instr_ready ? instr_valid : s1_valid_reg;
    assign res_valid_next = s1_fire ? s1_valid_reg : res_valid_reg;

    // Hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Capture incoming item
    always_ff @(posedge clk)
    begin
        if (instr_valid && instr_ready)
        begin
            s1_reg <= instr;
        end
    end

    awbsf_shifter u_shifter (
        .item  (s1_reg),
        .shift (shift)
    );

    awbsf_alu u_alu (
        .item  (s1_reg),
        .shift (shift),
        .res   (alu_res)
    );

    // Capture finished item
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_valid_reg)
        begin
            res_reg <= alu_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// ----- sv/awbsf_checker.sv -----
module awbsf_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  instr_valid,
    input logic                  instr_ready,
    input awbsf_pkg::awbsf_in_t  instr,
    input logic                  res_valid,
    input logic                  res_ready,
    input awbsf_pkg::awbsf_out_t res
);
    import awbsf_pkg::*;

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = instr_valid && instr_ready;
    assign out_acc = res_valid && res_ready;

    // Track items accepted but not yet delivered
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
        begin
            inflight_next = inflight_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            inflight_next = inflight_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= 2'd0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("stalled result changed or dropped");

    // No result without an item in flight
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> inflight_reg != 2'd0)
        else $error("result shown with no item in flight");

    // At most two items inside
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more than two items in flight");

    // An empty output stage never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> instr_ready)
        else $error("input stalled with empty output");

    // An item into an empty block passes the input and result registers unstalled
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && inflight_reg == 2'd0 |-> ##2
        res_valid && res.dest_index == $past(instr.instruction[15:12], 2))
        else $error("item did not arrive after two cycles");

endmodule

bind alu_with_barrel_shifter_flags_core awbsf_checker u_awbsf_checker (.*);

// ----- tb/alu_with_barrel_shifter_flags_core_test.sv -----
`timescale 1ns / 100ps

module alu_with_barrel_shifter_flags_core_test;

    import awbsf_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 12;
    localparam int IDLE_PCT        = 33;
    localparam int HOLD_OFF_CYCLES = 40;
    localparam int DRAIN_CYCLES    = 8;

    // Adder output with carry and signed overflow
    typedef struct packed {
        logic [31:0] sum;
        logic        carry;
        logic        overflow;
    } sum_t;

    // One directed item, with a hand-written result where typed is set
    typedef struct {
        awbsf_in_t  item;
        logic       typed;
        awbsf_out_t want;
    } stimulus_row_t;

    logic       clk;
    logic       rst_n;
    logic       instr_valid;
    logic       instr_ready;
    awbsf_in_t  instr;
    logic       res_valid;
    logic       res_ready;
    awbsf_out_t res;

    awbsf_out_t    awaited_results[$];
    stimulus_row_t stimulus_rows[$];
    awbsf_out_t    oldest;
    int            error_count = 0;
    int            sender_idle_pct;
    int            receiver_idle_pct;
    logic          hold_off_request;

    alu_with_barrel_shifter_flags_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_valid (instr_valid),
        .instr_ready (instr_ready),
        .instr       (instr),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    always
    begin
        clk = 1'b0;
        #(HALF_PERIOD);
        clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Data-processing word, condition always, Rn fixed at r1
    function automatic logic [31:0] dp_word(awbsf_op_t op, logic s_bit, logic [3:0] rd,
                                            logic imm_form, logic [11:0] operand2);
        return {4'hE, 2'b00, imm_form, op, s_bit, 4'h1, rd, operand2};
    endfunction

    // Rm shifted by an immediate amount
    function automatic logic [11:0] shift_imm(logic [4:0] amount, awbsf_shtype_t kind);
        return {amount, kind, 1'b0, 4'h2};
    endfunction

    // Rm shifted by the low byte of Rs
    function automatic logic [11:0] shift_reg(awbsf_shtype_t kind);
        return {4'h3, 1'b0, kind, 1'b1, 4'h2};
    endfunction

    function automatic logic [31:0] rotate_right(logic [31:0] value, logic [4:0] amount);
        logic [63:0] both;
        both = {value, value} >> amount;
        return both[31:0];
    endfunction

    // Operand value biased toward the corners of the range
    function automatic logic [31:0] random_word();
        logic [31:0] word;
        case ($urandom_range(0, 7))
            0: word = 32'h0000_0000;
            1: word = 32'hFFFF_FFFF;
            2: word = 32'h8000_0000;
            3: word = 32'h7FFF_FFFF;
            default: word = $urandom;
        endcase
        return word;
    endfunction

    // Second operand and shifter carry out
    function automatic awbsf_shift_t shift_operand(awbsf_in_t item);
        awbsf_shift_t  sh;
        awbsf_shtype_t kind;
        logic [31:0]   rm;
        logic [63:0]   spread;
        logic [7:0]    amount;
        logic [4:0]    imm_amount;
        logic [4:0]    rot;
        logic          sign;
        rm = item.shift_source;
        sign = rm[31];
        kind = awbsf_shtype_t'(item.instruction[6:5]);
        amount = item.shift_register_value[7:0];
        imm_amount = item.instruction[11:7];
        if (item.instruction[25])
        begin
            rot = {item.instruction[11:8], 1'b0};
            sh.operand = rotate_right({24'b0, item.instruction[7:0]}, rot);
            sh.carry = (rot == 5'd0) ? item.c_flag_in : sh.operand[31];
        end
        else if (item.instruction[4])
        begin
            if (amount == 8'd0)
            begin
                sh.operand = rm;
                sh.carry = item.c_flag_in;
            end
            else
            begin
                case (kind)
                    SH_LSL:
                    begin
                        sh.operand = (amount < 8'd32) ? rm << amount : 32'h0;
                        if (amount < 8'd32)
                            sh.carry = rm[32 - amount];
                        else
                            sh.carry = (amount == 8'd32) ? rm[0] : 1'b0;
                    end
                    SH_LSR:
                    begin
                        sh.operand = (amount < 8'd32) ? rm >> amount : 32'h0;
                        if (amount < 8'd32)
                            sh.carry = rm[amount - 1];
                        else
                            sh.carry = (amount == 8'd32) ? sign : 1'b0;
                    end
                    SH_ASR:
                    begin
                        if (amount < 8'd32)
                        begin
                            spread = {{32{sign}}, rm} >> amount;
                            sh.operand = spread[31:0];
                            sh.carry = rm[amount - 1];
                        end
                        else
                        begin
                            sh.operand = {32{sign}};
                            sh.carry = sign;
                        end
                    end
                    default:
                    begin
                        if (amount[4:0] == 5'd0)
                        begin
                            sh.operand = rm;
                            sh.carry = sign;
                        end
                        else
                        begin
                            sh.operand = rotate_right(rm, amount[4:0]);
                            sh.carry = rm[amount[4:0] - 1];
                        end
                    end
                endcase
            end
        end
        else
        begin
            // Zero amount encodes LSR #32, ASR #32 and RRX
            case (kind)
                SH_LSL:
                begin
                    sh.operand = rm << imm_amount;
                    sh.carry = (imm_amount == 5'd0) ? item.c_flag_in : rm[32 - imm_amount];
                end
                SH_LSR:
                begin
                    sh.operand = (imm_amount == 5'd0) ? 32'h0 : rm >> imm_amount;
                    sh.carry = (imm_amount == 5'd0) ? sign : rm[imm_amount - 1];
                end
                SH_ASR:
                begin
                    spread = {{32{sign}}, rm} >> ((imm_amount == 5'd0) ? 6'd32 : imm_amount);
                    sh.operand = spread[31:0];
                    sh.carry = (imm_amount == 5'd0) ? sign : rm[imm_amount - 1];
                end
                default:
                begin
                    if (imm_amount == 5'd0)
                    begin
                        sh.operand = {item.c_flag_in, rm[31:1]};
                        sh.carry = rm[0];
                    end
                    else
                    begin
                        sh.operand = rotate_right(rm, imm_amount);
                        sh.carry = rm[imm_amount - 1];
                    end
                end
            endcase
        end
        return sh;
    endfunction

    function automatic sum_t add_with_carry(logic [31:0] a, logic [31:0] b, logic cin);
        logic [32:0] total;
        sum_t        s;
        total = {1'b0, a} + {1'b0, b} + {32'b0, cin};
        s.sum = total[31:0];
        s.carry = total[32];
        s.overflow = (a[31] ^ s.sum[31]) & (b[31] ^ s.sum[31]);
        return s;
    endfunction

    // Full execute result of one data-processing instruction
    function automatic awbsf_out_t predict_execution(awbsf_in_t item);
        awbsf_out_t   want;
        awbsf_shift_t op2;
        awbsf_op_t    op;
        sum_t         total;
        logic [31:0]  a;
        logic [31:0]  b;
        logic         arith;
        logic         s_bit;
        op = awbsf_op_t'(item.instruction[24:21]);
        s_bit = item.instruction[20];
        a = item.first_operand;
        op2 = shift_operand(item);
        b = op2.operand;
        arith = 1'b1;
        total = '0;
        want.flag_c = op2.carry;
        want.flag_v = item.overflow_in;
        want.result = 32'h0;
        case (op)
            OP_AND, OP_TST: begin want.result = a & b;  arith = 1'b0; end
            OP_EOR, OP_TEQ: begin want.result = a ^ b;  arith = 1'b0; end
            OP_ORR:         begin want.result = a | b;  arith = 1'b0; end
            OP_MOV:         begin want.result = b;      arith = 1'b0; end
            OP_BIC:         begin want.result = a & ~b; arith = 1'b0; end
            OP_MVN:         begin want.result = ~b;     arith = 1'b0; end
            OP_SUB, OP_CMP: total = add_with_carry(a, ~b, 1'b1);
            OP_RSB:         total = add_with_carry(b, ~a, 1'b1);
            OP_ADD, OP_CMN: total = add_with_carry(a, b, 1'b0);
            OP_ADC:         total = add_with_carry(a, b, item.c_flag_in);
            OP_SBC:         total = add_with_carry(a, ~b, item.c_flag_in);
            default:        total = add_with_carry(b, ~a, item.c_flag_in);
        endcase
        if (arith)
        begin
            want.result = total.sum;
            want.flag_c = total.carry;
            want.flag_v = total.overflow;
        end
        want.dest_index = item.instruction[15:12];
        want.write_dest = !(op inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
        want.restore_saved_status = s_bit && want.dest_index == PC_INDEX
                                    && item.privileged;
        want.flags_update = s_bit && !want.restore_saved_status;
        want.flag_n = want.result[31];
        want.flag_z = (want.result == 32'h0);
        want.extra_cycle = !item.instruction[25] && item.instruction[4];
        return want;
    endfunction

    task automatic add_row(input awbsf_in_t item, input logic typed, input awbsf_out_t want);
        stimulus_row_t row;
        row.item = item;
        row.typed = typed;
        row.want = want;
        stimulus_rows.push_back(row);
    endtask

    // Offer one item after a random gap; log its result once accepted
    task automatic send_item(input awbsf_in_t item, input logic typed, input awbsf_out_t want);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            instr_valid <= 1'b0;
            @(posedge clk);
        end
        instr_valid <= 1'b1;
        instr <= item;
        do
            @(posedge clk);
        while (!instr_ready);
        if (typed)
            awaited_results.push_back(want);
        else
            awaited_results.push_back(predict_execution(item));
    endtask

    // Drop valid and hold until every result is back
    task automatic wait_for_results();
        instr_valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_results.size() != 0);
    endtask

    task automatic run_random(input int count);
        awbsf_in_t item;
        repeat (count)
        begin
            item.instruction = $urandom;
            item.first_operand = random_word();
            item.shift_source = random_word();
            item.shift_register_value = $urandom;
            // Steer register shift amounts around 0, 32 and its multiples
            case ($urandom_range(0, 3))
                0: item.shift_register_value[7:0] = 8'($urandom_range(0, 31));
                1: item.shift_register_value[7:0] = 8'($urandom_range(0, 7) * 32);
                2: item.shift_register_value[7:0] = 8'($urandom_range(31, 33));
                default: ;
            endcase
            item.c_flag_in = 1'($urandom_range(0, 1));
            item.overflow_in = 1'($urandom_range(0, 1));
            item.privileged = 1'($urandom_range(0, 1));
            send_item(item, 1'b0, '0);
        end
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Compare each returned item with the oldest one awaited
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_ready === 1'b1)
        begin
            if (awaited_results.size() == 0)
            begin
                $display("%0t: unexpected result item %h", $time, res);
                error_count++;
            end
            else
            begin
                oldest = awaited_results.pop_front();
                check_field("result", oldest.result, res.result);
                check_field("write_dest", oldest.write_dest, res.write_dest);
                check_field("dest_index", oldest.dest_index, res.dest_index);
                check_field("flags_update", oldest.flags_update, res.flags_update);
                check_field("flag_n", oldest.flag_n, res.flag_n);
                check_field("flag_z", oldest.flag_z, res.flag_z);
                check_field("flag_c", oldest.flag_c, res.flag_c);
                check_field("flag_v", oldest.flag_v, res.flag_v);
                check_field("restore_saved_status", oldest.restore_saved_status,
                            res.restore_saved_status);
                check_field("extra_cycle", oldest.extra_cycle, res.extra_cycle);
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial
    begin
        res_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                res_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            res_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
        end
    end

    // Sender: reset, directed table, then random phases
    initial
    begin
        instr_valid <= 1'b0;
        instr <= '0;
        rst_n <= 1'b0;
        sender_idle_pct = IDLE_PCT;
        receiver_idle_pct = IDLE_PCT;
        hold_off_request = 1'b0;

        // Results readable by hand
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, 4'd0, 1'b1, 12'h000), 32'h1234_5678,
                            32'h0, 32'h0, 1'b1, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'h0, 1'b1, 4'd0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0});
        add_row(awbsf_in_t'{dp_word(OP_ADD, 1'b1, 4'd2, 1'b0, shift_imm(5'd0, SH_LSL)),
                            32'hFFFF_FFFF, 32'h1, 32'h0, 1'b0, 1'b1, 1'b0}, 1'b1,
                awbsf_out_t'{32'h0, 1'b1, 4'd2, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0});
        add_row(awbsf_in_t'{dp_word(OP_ADD, 1'b1, 4'd3, 1'b0, shift_imm(5'd0, SH_LSL)),
                            32'h7FFF_FFFF, 32'h1, 32'h0, 1'b1, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'h8000_0000, 1'b1, 4'd3, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1,
                             1'b0, 1'b0});
        add_row(awbsf_in_t'{dp_word(OP_SUB, 1'b1, 4'd4, 1'b0, shift_imm(5'd0, SH_LSL)),
                            32'h0, 32'h1, 32'h0, 1'b0, 1'b1, 1'b0}, 1'b1,
                awbsf_out_t'{32'hFFFF_FFFF, 1'b1, 4'd4, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                             1'b0, 1'b0});
        add_row(awbsf_in_t'{dp_word(OP_CMP, 1'b1, 4'd0, 1'b0, shift_imm(5'd0, SH_LSL)),
                            32'h8000_0000, 32'h1, 32'h0, 1'b0, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'h7FFF_FFFF, 1'b0, 4'd0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1,
                             1'b0, 1'b0});
        // Flag-setting write to the PC: restore in a privileged mode only
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, PC_INDEX, 1'b1, 12'h000), 32'h0,
                            32'h0, 32'h0, 1'b0, 1'b0, 1'b1}, 1'b1,
                awbsf_out_t'{32'h0, 1'b1, PC_INDEX, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0});
        add_row(awbsf_in_t'{dp_word(OP_CMP, 1'b1, PC_INDEX, 1'b1, 12'h005), 32'h5,
                            32'h0, 32'h0, 1'b0, 1'b1, 1'b1}, 1'b1,
                awbsf_out_t'{32'h0, 1'b0, PC_INDEX, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0});
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, PC_INDEX, 1'b1, 12'h0FF), 32'h0,
                            32'h0, 32'h0, 1'b1, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'hFF, 1'b1, PC_INDEX, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0});
        // Register shift amounts of zero, 32 and beyond
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, 4'd5, 1'b0, shift_reg(SH_LSL)), 32'h0,
                            32'h8000_0001, 32'h0000_0F00, 1'b1, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'h8000_0001, 1'b1, 4'd5, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                             1'b0, 1'b1});
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, 4'd6, 1'b0, shift_reg(SH_LSL)), 32'h0,
                            32'h1, 32'd32, 1'b0, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'h0, 1'b1, 4'd6, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1});
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, 4'd7, 1'b0, shift_reg(SH_LSR)), 32'h0,
                            32'h8000_0000, 32'd32, 1'b0, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'h0, 1'b1, 4'd7, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1});
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, 4'd8, 1'b0, shift_reg(SH_ASR)), 32'h0,
                            32'h8000_0000, 32'hC8, 1'b0, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'hFFFF_FFFF, 1'b1, 4'd8, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                             1'b0, 1'b1});
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, 4'd9, 1'b0, shift_reg(SH_ROR)), 32'h0,
                            32'h8000_0001, 32'h40, 1'b0, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'h8000_0001, 1'b1, 4'd9, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                             1'b0, 1'b1});
        // Rotate through carry, then a nonzero immediate rotate
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, 4'd10, 1'b0, shift_imm(5'd0, SH_ROR)),
                            32'h0, 32'h3, 32'h0, 1'b1, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'h8000_0001, 1'b1, 4'd10, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                             1'b0, 1'b0});
        add_row(awbsf_in_t'{dp_word(OP_MOV, 1'b1, 4'd11, 1'b1, 12'h4FF), 32'h0, 32'h0,
                            32'h0, 1'b0, 1'b0, 1'b0}, 1'b1,
                awbsf_out_t'{32'hFF00_0000, 1'b1, 4'd11, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0,
                             1'b0, 1'b0});

        // Remaining operations against the predictor
        add_row(awbsf_in_t'{dp_word(OP_AND, 1'b1, 4'd1, 1'b0, shift_reg(SH_LSL)),
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd33, 1'b1, 1'b0, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_EOR, 1'b1, 4'd2, 1'b0, shift_reg(SH_LSR)), 32'h0,
                            32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_RSB, 1'b1, 4'd3, 1'b0, shift_imm(5'd0, SH_LSR)),
                            32'h1, 32'h8000_0000, 32'h0, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_ADC, 1'b1, 4'd4, 1'b0, shift_imm(5'd0, SH_ASR)),
                            32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b1, 1'b0, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_SBC, 1'b0, 4'd5, 1'b0, shift_imm(5'd0, SH_LSL)),
                            32'h0, 32'h0, 32'h0, 1'b0, 1'b1, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_RSC, 1'b1, 4'd6, 1'b0, shift_imm(5'd31, SH_LSL)),
                            32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 1'b0, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_TST, 1'b1, 4'd0, 1'b1, 12'hF01), 32'hFFFF_FFFF,
                            32'h0, 32'h0, 1'b0, 1'b1, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_TEQ, 1'b1, 4'd0, 1'b0, shift_imm(5'd5, SH_ROR)),
                            32'h1234_5678, 32'h1234_5678, 32'h0, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_CMN, 1'b1, 4'd0, 1'b1, 12'h001), 32'hFFFF_FFFF,
                            32'h0, 32'h0, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_ORR, 1'b0, 4'd14, 1'b0, shift_imm(5'd1, SH_ASR)),
                            32'h0, 32'h8000_0000, 32'h0, 1'b0, 1'b1, 1'b0}, 1'b0, '0);
        add_row(awbsf_in_t'{dp_word(OP_BIC, 1'b1, 4'd12, 1'b0, shift_reg(SH_ASR)),
                            32'hFFFF_FFFF, 32'h8000_0000, 32'd31, 1'b0, 1'b0, 1'b0}, 1'b0, '0);
        // Words outside the data-processing class decode all the same
        add_row(awbsf_in_t'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            1'b1, 1'b1, 1'b1}, 1'b0, '0);
        add_row(awbsf_in_t'{32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 1'b0}, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        foreach (stimulus_rows[i])
            send_item(stimulus_rows[i].item, stimulus_rows[i].typed, stimulus_rows[i].want);

        // Random items with idling on both sides
        run_random(400);

        // Stretch with no idling at all
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        run_random(250);

        // Long receiver hold-off while items keep coming, then a full pause
        hold_off_request = 1'b1;
        run_random(80);
        wait_for_results();

        sender_idle_pct = IDLE_PCT;
        receiver_idle_pct = IDLE_PCT;
        run_random(570);

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/awbsf_pkg.sv
sv/awbsf_shifter.sv
sv/awbsf_alu.sv
sv/alu_with_barrel_shifter_flags_core.sv
sv/awbsf_checker.sv
tb/alu_with_barrel_shifter_flags_core_test.sv
